// File: hdl/owsdq_pkg.sv
// ----------------------------------------------------------------------------
// owsdq_pkg: shared types and constants of the one-way scan disk queue
// Command and status codes, slot and cell-control structures, and defaults.
// ----------------------------------------------------------------------------
package owsdq_pkg;

    // Default number of queue slots
    localparam int QueueDepthDefault = 32;

    // Field widths fixed by the word format
    localparam int CylW   = 16;
    localparam int TagW   = 8;
    localparam int QcntW  = 6;
    localparam int SDataW = 24;
    localparam int MDataW = 32;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // One queue slot; run2 marks the wrapped (already passed) run
    typedef struct packed {
        logic            valid;
        logic            run2;
        logic [CylW-1:0] cyl;
        logic [TagW-1:0] tag;
    } t_slot;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic            ins;
        logic            load_head;
        logic            pop;
        logic            clr_run2;
        logic            new_run2;
        logic [CylW-1:0] new_cyl;
        logic [TagW-1:0] new_tag;
    } t_cell_ctrl;

    localparam t_slot SLOT_NONE = '0;

endpackage

// File: hdl/owsdq_cell.sv
// ----------------------------------------------------------------------------
// owsdq_cell: one slot of the elevator queue chain
// Holds one request, decides locally whether an insert lands at or before it,
// and shifts right on insert or left on removal using its neighbours only.
// ----------------------------------------------------------------------------
module owsdq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  owsdq_pkg::t_cell_ctrl  i_ctrl,
    input  owsdq_pkg::t_slot       i_prev,
    input  logic                   i_prev_go,
    input  owsdq_pkg::t_slot       i_next,
    output owsdq_pkg::t_slot       o_slot,
    output logic                   o_go
);
    import owsdq_pkg::*;

    logic            r_valid, n_valid;
    logic            r_run2,  n_run2;
    logic [CylW-1:0] r_cyl,   n_cyl;
    logic [TagW-1:0] r_tag,   n_tag;
    logic            w_less;

    assign w_less = i_ctrl.new_cyl < r_cyl;

    // Insert point is at or before this slot; the head never moves aside
    always_comb begin
        if (IS_HEAD) begin
            o_go = 1'b0;
        end else if (!r_valid) begin
            o_go = 1'b1;
        end else if (i_ctrl.new_run2) begin
            o_go = r_run2 && w_less;
        end else begin
            o_go = r_run2 || w_less;
        end
    end

    // Select the slot's next contents
    always_comb begin
        n_valid = r_valid;
        n_run2  = r_run2;
        n_cyl   = r_cyl;
        n_tag   = r_tag;
        if (i_ctrl.pop) begin
            n_valid = i_next.valid;
            n_run2  = i_next.run2 & ~i_ctrl.clr_run2;
            n_cyl   = i_next.cyl;
            n_tag   = i_next.tag;
        end else if (IS_HEAD && i_ctrl.load_head) begin
            n_valid = 1'b1;
            n_run2  = 1'b0;
            n_cyl   = i_ctrl.new_cyl;
            n_tag   = i_ctrl.new_tag;
        end else if (i_ctrl.ins && o_go) begin
            if (!i_prev_go) begin
                n_valid = 1'b1;
                n_run2  = i_ctrl.new_run2;
                n_cyl   = i_ctrl.new_cyl;
                n_tag   = i_ctrl.new_tag;
            end else begin
                n_valid = i_prev.valid;
                n_run2  = i_prev.run2;
                n_cyl   = i_prev.cyl;
                n_tag   = i_prev.tag;
            end
        end
    end

    // Control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_run2  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_run2  <= n_run2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cyl <= n_cyl;
        r_tag <= n_tag;
    end

    assign o_slot = '{valid: r_valid, run2: r_run2, cyl: r_cyl, tag: r_tag};

endmodule

// File: hdl/one_way_scan_disk_queue_unit.sv
// Each result word is registered when its input is taken. Throughput: one word per cycle
// while the skid word is empty; every cell compares the new cylinder with its own and hands
// its slot to a neighbour in that same cycle, and a two-word output stage absorbs stalls.
// Reset (synchronous, active low) clears the slot valid bits, the count and the output
// stage at once; slot contents are left as they are and no clearing pass is needed.
// ----------------------------------------------------------------------------
// one_way_scan_disk_queue_unit: one-way elevator disk request queue
// Chain of slot cells kept in circular scan order; insert and remove words in,
// one status word out per input word.
// ----------------------------------------------------------------------------
module one_way_scan_disk_queue_unit #(
    parameter int QUEUE_DEPTH = owsdq_pkg::QueueDepthDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [owsdq_pkg::SDataW-1:0] i_s_tdata,  // [15:0] cylinder, [23:16] request_tag
    input  logic                         i_s_tuser,  // [0] command
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [owsdq_pkg::MDataW-1:0] o_m_tdata,  // [15:0] out_cylinder, [23:16] out_tag,
                                                     // [29:24] queue_count, [31:30] zero
    output logic [1:0]                   o_m_tuser   // [1:0] status
);
    import owsdq_pkg::*;

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_slot           w_slot [QUEUE_DEPTH];
    logic            w_go   [QUEUE_DEPTH];
    t_cell_ctrl      w_ctrl;
    logic            w_acc;
    t_cmd            w_cmd;
    logic [CylW-1:0] w_cyl_in;
    logic [TagW-1:0] w_tag_in;
    logic            w_full;

    logic [CntW-1:0]   r_count, n_count;
    logic [CntW+5:0]   w_cnt_ext;
    t_status           w_status;
    logic [CylW-1:0]   w_ocyl;
    logic [TagW-1:0]   w_otag;
    logic [MDataW-1:0] w_res_data;

    logic              r_ov, r_sv;
    logic [MDataW-1:0] r_odata, r_sdata;
    logic [1:0]        r_ouser, r_suser;
    logic              w_opop;

    assign w_acc    = i_s_tvalid && o_s_tready;
    assign w_cmd    = t_cmd'(i_s_tuser);
    assign w_cyl_in = i_s_tdata[CylW-1:0];
    assign w_tag_in = i_s_tdata[CylW+TagW-1:CylW];
    assign w_full   = w_slot[QUEUE_DEPTH-1].valid;

    // Broadcast control to the chain
    always_comb begin
        w_ctrl.ins       = w_acc && (w_cmd == CMD_INSERT) && w_slot[0].valid && !w_full;
        w_ctrl.load_head = w_acc && (w_cmd == CMD_INSERT) && !w_slot[0].valid;
        w_ctrl.pop       = w_acc && (w_cmd == CMD_REMOVE) && w_slot[0].valid;
        w_ctrl.clr_run2  = w_slot[1].run2;
        w_ctrl.new_run2  = w_cyl_in < w_slot[0].cyl;
        w_ctrl.new_cyl   = w_cyl_in;
        w_ctrl.new_tag   = w_tag_in;
    end

    // Cell chain
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        t_slot w_prev, w_next;
        logic  w_prev_go;
        if (k == 0) begin : g_first
            assign w_prev    = SLOT_NONE;
            assign w_prev_go = 1'b1;
        end else begin : g_mid
            assign w_prev    = w_slot[k-1];
            assign w_prev_go = w_go[k-1];
        end
        if (k == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = SLOT_NONE;
        end else begin : g_nxt
            assign w_next = w_slot[k+1];
        end
        owsdq_cell #(
            .IS_HEAD (k == 0)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_prev    (w_prev),
            .i_prev_go (w_prev_go),
            .i_next    (w_next),
            .o_slot    (w_slot[k]),
            .o_go      (w_go[k])
        );
    end

    // Build the result word and the next count
    always_comb begin
        n_count  = r_count;
        w_ocyl   = '0;
        w_otag   = '0;
        if (w_cmd == CMD_INSERT) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_INSERTED;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (!w_slot[0].valid) begin
                w_status = ST_EMPTY;
            end else begin
                w_status = ST_REMOVED;
                w_ocyl   = w_slot[0].cyl;
                w_otag   = w_slot[0].tag;
                n_count  = r_count - 1'b1;
            end
        end
    end

    assign w_cnt_ext  = {6'b0, n_count};
    assign w_res_data = {2'b00, w_cnt_ext[QcntW-1:0], w_otag, w_ocyl};

    // Hold the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    // Output register with skid word
    assign o_s_tready = !r_sv;
    assign w_opop     = r_ov && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_opop) begin
                r_sv <= 1'b0;
            end
        end else if (w_acc) begin
            if (r_ov && !w_opop) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (w_opop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_opop) begin
                r_odata <= r_sdata;
                r_ouser <= r_suser;
            end
        end else if (w_acc) begin
            if (r_ov && !w_opop) begin
                r_sdata <= w_res_data;
                r_suser <= w_status;
            end else begin
                r_odata <= w_res_data;
                r_ouser <= w_status;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule

// File: hdl/owsdq_checker.sv
// ----------------------------------------------------------------------------
// owsdq_checker: port-level checks for the one-way scan disk queue
// Watches the result stream and flags words that break the word format or the handshake.
// ----------------------------------------------------------------------------
module owsdq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [owsdq_pkg::MDataW-1:0] o_m_tdata,
    input logic [1:0]                   o_m_tuser
);
    import owsdq_pkg::*;

    // Output stage is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("result word present right after reset");

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed");

    // Dropped inserts and empty removes carry no request
    a_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_FULL || o_m_tuser == ST_EMPTY)
            |-> o_m_tdata[SDataW-1:0] == '0)
        else $error("request fields set on a drop or empty word");

    // Remove from an empty queue leaves the count at zero
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_EMPTY |-> o_m_tdata[MDataW-1:SDataW] == '0)
        else $error("non-zero count on an empty-queue word");

    // Upper padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[MDataW-1:SDataW+QcntW] == '0)
        else $error("padding bits set in result word");

endmodule

bind one_way_scan_disk_queue_unit owsdq_checker u_owsdq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: tb/sv/tb_one_way_scan_disk_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_way_scan_disk_queue_unit: self-checking bench for the C-SCAN request queue
// Drives insert and remove words through the input stream under bursty traffic and
// a stalling receiver. Every returned status word is compared with a table entry or
// a behavioural elevator queue kept alongside. A short table of hand-picked words
// runs first, then random phases that swing between filling and draining the queue.
// ----------------------------------------------------------------------------
module tb_one_way_scan_disk_queue_unit;
    import owsdq_pkg::*;

    localparam int DEPTH          = QueueDepthDefault;
    localparam int RANDOM_WORDS   = 1000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIR_ROWS       = 26;

    // Fields of one status word as returned by the block
    typedef struct packed {
        t_status           st;
        logic [CylW-1:0]   cyl;
        logic [TagW-1:0]   tag;
        logic [QcntW-1:0]  cnt;
    } t_sched_word;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        t_cmd              cmd;
        logic [CylW-1:0]   cyl;
        logic [TagW-1:0]   tag;
        logic              typed;
        t_sched_word       want;
    } t_dir_row;

    localparam t_sched_word NO_WORD = '{ST_INSERTED, 16'h0, 8'h0, 6'd0};

    // Hand-picked sequence: empty remove, both runs, equal cylinders, full drain
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{CMD_REMOVE, 16'h1234, 8'h56, 1'b1, '{ST_EMPTY,    16'h0,    8'h0,  6'd0}},
        '{CMD_INSERT, 16'h8000, 8'hFF, 1'b1, '{ST_INSERTED, 16'h0,    8'h0,  6'd1}},
        '{CMD_INSERT, 16'hFFFF, 8'h01, 1'b0, NO_WORD},
        '{CMD_INSERT, 16'h0000, 8'h00, 1'b0, NO_WORD},
        '{CMD_INSERT, 16'h8000, 8'hAA, 1'b0, NO_WORD},
        '{CMD_INSERT, 16'h4000, 8'h55, 1'b0, NO_WORD},
        '{CMD_INSERT, 16'h0000, 8'h5A, 1'b0, NO_WORD},
        '{CMD_INSERT, 16'h7FFF, 8'hA5, 1'b0, NO_WORD},
        '{CMD_INSERT, 16'h8001, 8'h3C, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'hFFFF, 8'hFF, 1'b1, '{ST_REMOVED,  16'h8000, 8'hFF, 6'd7}},
        '{CMD_INSERT, 16'hFFFF, 8'hC3, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'h0000, 8'h00, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'hAAAA, 8'h55, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'h5555, 8'hAA, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'hFFFF, 8'hFF, 1'b0, NO_WORD},
        '{CMD_INSERT, 16'h0000, 8'h0F, 1'b0, NO_WORD},
        '{CMD_INSERT, 16'h1234, 8'hF0, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'h0000, 8'h00, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'hFFFF, 8'hFF, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'h0F0F, 8'h0F, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'hF0F0, 8'hF0, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'h0000, 8'h00, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'hFFFF, 8'hFF, 1'b0, NO_WORD},
        '{CMD_REMOVE, 16'hFFFF, 8'hFF, 1'b1, '{ST_EMPTY,    16'h0,    8'h0,  6'd0}},
        '{CMD_INSERT, 16'h5000, 8'h11, 1'b1, '{ST_INSERTED, 16'h0,    8'h0,  6'd1}},
        '{CMD_INSERT, 16'h2000, 8'h22, 1'b0, NO_WORD}
    };

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [SDataW-1:0]    i_s_tdata  = '0;   // [15:0] cylinder, [23:16] request_tag
    logic                 i_s_tuser  = 1'b0; // [0] command
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [MDataW-1:0]    o_m_tdata;         // [15:0] out_cylinder, [23:16] out_tag,
                                             // [29:24] queue_count, [31:30] zero
    logic [1:0]           o_m_tuser;         // [1:0] status

    // Behavioural copy of the queue, in service order
    logic [CylW-1:0]      q_cyl [DEPTH];
    logic [TagW-1:0]      q_tag [DEPTH];
    int                   q_count = 0;

    t_sched_word          awaited_q [$];
    int                   fail_count   = 0;
    int                   idle_cycles  = 0;
    int                   burst_left   = 0;
    logic [15:0]          stall_mask   = 16'hFFFF;
    int                   stall_span   = 0;

    one_way_scan_disk_queue_unit #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Slot after which a new request lands: first run if at or above the head,
    // otherwise past the inversion, behind any equal cylinders
    function automatic int insert_after(input logic [CylW-1:0] cyl);
        int i;
        int n;
        i = 0;
        n = q_count;
        if (cyl < q_cyl[0]) begin
            while (i + 1 < n) begin
                if (q_cyl[i + 1] < q_cyl[i]) begin
                    while (i + 1 < n) begin
                        if (cyl < q_cyl[i + 1]) return i;
                        i++;
                    end
                    return i;
                end
                i++;
            end
            return i;
        end
        while (i + 1 < n) begin
            if (q_cyl[i + 1] < q_cyl[i] || cyl < q_cyl[i + 1]) return i;
            i++;
        end
        return i;
    endfunction

    // Apply one command to the queue copy and return the status word it yields
    function automatic t_sched_word elevator_step(input t_cmd cmd,
                                                  input logic [CylW-1:0] cyl,
                                                  input logic [TagW-1:0] tag);
        t_sched_word res;
        int pos;
        res = NO_WORD;
        if (cmd == CMD_INSERT) begin
            if (q_count >= DEPTH) begin
                res.st = ST_FULL;
            end else begin
                pos = (q_count == 0) ? 0 : insert_after(cyl) + 1;
                for (int k = q_count; k > pos; k--) begin
                    q_cyl[k] = q_cyl[k - 1];
                    q_tag[k] = q_tag[k - 1];
                end
                q_cyl[pos] = cyl;
                q_tag[pos] = tag;
                q_count++;
                res.st = ST_INSERTED;
            end
        end else if (q_count == 0) begin
            res.st = ST_EMPTY;
        end else begin
            res.st  = ST_REMOVED;
            res.cyl = q_cyl[0];
            res.tag = q_tag[0];
            for (int k = 0; k + 1 < q_count; k++) begin
                q_cyl[k] = q_cyl[k + 1];
                q_tag[k] = q_tag[k + 1];
            end
            q_count--;
        end
        res.cnt = QcntW'(q_count);
        return res;
    endfunction

    // Cylinder for a random insert: spread, clustered, extremes or close to the head
    function automatic logic [CylW-1:0] pick_cylinder(input int mode);
        logic [CylW-1:0] c;
        c = CylW'($urandom);
        case (mode)
            1: begin
                c = CylW'($urandom_range(7));
            end
            2: begin
                case ($urandom_range(3))
                    0: c = 16'h0000;
                    1: c = 16'hFFFF;
                    2: c = 16'h8000;
                    default: c = 16'h7FFF;
                endcase
            end
            3: begin
                if (q_count > 0) c = q_cyl[0] + CylW'($urandom_range(6)) - 16'd3;
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what, input t_sched_word want,
                                   input t_sched_word got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display({"[%0t] %s: expected st=%0d cyl=%h tag=%h cnt=%0d, ",
                      "got st=%0d cyl=%h tag=%h cnt=%0d"},
                     $realtime, what, want.st, want.cyl, want.tag, want.cnt,
                     got.st, got.cyl, got.tag, got.cnt);
    endtask

    // Offer one word, keeping bursts and gaps; predict once it is taken
    task automatic send_word(input t_cmd cmd, input logic [CylW-1:0] cyl,
                             input logic [TagW-1:0] tag, output t_sched_word predicted);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {tag, cyl};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
        predicted = elevator_step(cmd, cyl, tag);
    endtask

    // Hold the sender off until every outstanding status word has returned
    task automatic drain_pause();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (awaited_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: stall on a rotating mask, reloaded per span, sometimes all ready
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_span <= $urandom_range(8, 64);
            stall_mask <= ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom);
            i_m_tready <= stall_mask[0];
        end else begin
            stall_span <= stall_span - 1;
            stall_mask <= {stall_mask[0], stall_mask[15:1]};
            i_m_tready <= stall_mask[0];
        end
    end

    // Compare each returned word with the oldest prediction; watch for a hang
    always @(posedge i_clk) begin : check_words
        t_sched_word got;
        t_sched_word want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.st  = t_status'(o_m_tuser);
                got.cyl = o_m_tdata[15:0];
                got.tag = o_m_tdata[23:16];
                got.cnt = o_m_tdata[29:24];
                if (awaited_q.size() == 0) begin
                    report_mismatch("unexpected word", NO_WORD, got);
                end else begin
                    want = awaited_q.pop_front();
                    if (got !== want || o_m_tdata[31:30] !== 2'b00)
                        report_mismatch("word mismatch", want, got);
                end
            end
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus: reset, directed table, random fill and drain phases, wind-down
    initial begin : stimulus
        t_sched_word pred;
        int sent;
        int ins_pct;
        int phase_len;
        int cyl_mode;
        t_cmd cmd;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_word(DIR_TABLE[r].cmd, DIR_TABLE[r].cyl, DIR_TABLE[r].tag, pred);
            awaited_q.push_back(DIR_TABLE[r].typed ? DIR_TABLE[r].want : pred);
        end
        drain_pause();

        // Random phases leaning towards filling, mixing or draining the queue
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(2))
                0:       ins_pct = 92;
                1:       ins_pct = 55;
                default: ins_pct = 12;
            endcase
            phase_len = $urandom_range(20, 120);
            cyl_mode  = $urandom_range(3);
            for (int k = 0; k < phase_len; k++) begin
                cmd = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
                send_word(cmd, pick_cylinder(cyl_mode), TagW'($urandom), pred);
                awaited_q.push_back(pred);
                sent++;
            end
            if ($urandom_range(3) == 0) drain_pause();
        end

        // Wait out the last words, then let the output stage idle before the verdict
        i_s_tvalid <= 1'b0;
        while (awaited_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/owsdq_pkg.sv
hdl/owsdq_cell.sv
hdl/one_way_scan_disk_queue_unit.sv
hdl/owsdq_checker.sv
tb/sv/tb_one_way_scan_disk_queue_unit.sv
